[rtl/core/range_add_range_sum_2d_fenwick_defines.svh]
`ifndef RANGE_ADD_RANGE_SUM_2D_FENWICK_DEFINES_SVH
`define RANGE_ADD_RANGE_SUM_2D_FENWICK_DEFINES_SVH

// implication checked in the same cycle, held off during reset
`define RARS2D_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication checked in the cycle after the antecedent, also across reset
`define RARS2D_ASSERT_NEXT(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/rars2d_pkg.sv]
package rars2d_pkg;

   localparam int MAX_ROWS_DEF  = 64;
   localparam int MAX_COLS_DEF  = 64;
   localparam int SUM_WIDTH_DEF = 64;

   localparam int COORD_W   = 6;
   localparam int VALUE_W   = 32;
   localparam int RESULT_W  = 64;
   localparam int HALF_W    = 32;
   localparam int ACC_W     = 2 * HALF_W;
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 2'd1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SETUP,
      ST_WPROD,
      ST_MUL,
      ST_WALK_RD,
      ST_WALK_WR,
      ST_COMBINE
   } state_type;

endpackage

[rtl/core/range_add_range_sum_2d_fenwick.sv]
// 2d range add / range sum store. Four binary indexed trees share one memory word per cell
// (plain, row, column and both weighted), read through a registered port and written back.
// After reset the block clears the memory, one word a cycle, over all MAX_ROWS*MAX_COLS
// words while busy is high. A command is taken when start is high and busy low. Each command
// runs four corners one after another; a corner does setup and shared-multiplier work plus,
// per tree cell visited, a memory read, then a write back or accumulate, plus a step per
// tree row. The memory port and the walk over tree cells set a command's length. A query
// answers with rsp_valid high for exactly one cycle as busy falls; the receiver cannot
// stall, so the sum must be taken in that cycle. Adds give no response. Items with a
// coordinate at or beyond the sizes in use are dropped for adds and answered with
// rsp_out_of_range for queries, in the cycle after acceptance.
module range_add_range_sum_2d_fenwick #(
   parameter int MAX_ROWS  = rars2d_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS  = rars2d_pkg::MAX_COLS_DEF,
   parameter int SUM_WIDTH = rars2d_pkg::SUM_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic                                    req_cmd,
   input  logic        [rars2d_pkg::COORD_W-1:0]   req_row_lo,
   input  logic        [rars2d_pkg::COORD_W-1:0]   req_col_lo,
   input  logic        [rars2d_pkg::COORD_W-1:0]   req_row_hi,
   input  logic        [rars2d_pkg::COORD_W-1:0]   req_col_hi,
   input  logic signed [rars2d_pkg::VALUE_W-1:0]   req_add_value,
   output logic                                    rsp_valid,
   output logic signed [rars2d_pkg::RESULT_W-1:0]  rsp_rect_sum,
   output logic                                    rsp_out_of_range,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [rars2d_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [rars2d_pkg::CFG_W-1:0]     csr_wdata
);

   import rars2d_pkg::*;

   localparam int RW    = $clog2(MAX_ROWS) + 2;
   localparam int CW    = $clog2(MAX_COLS) + 2;
   localparam int WA    = RW + CW;
   localparam int PW    = WA + HALF_W;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam int MW    = 4 * SUM_WIDTH;

   state_type state_ff, state_in;

   logic [CFG_W-1:0]    rows_in_use_ff, cols_in_use_ff;
   logic [AW-1:0]       clr_ff, clr_in;
   logic [1:0]          k_ff, k_in;
   logic [1:0]          mop_ff, mop_in;
   logic [1:0]          mph_ff, mph_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                cmd_ff, cmd_in;
   logic [COORD_W-1:0]  rl_ff, rl_in, cl_ff, cl_in, rh_ff, rh_in, ch_ff, ch_in;
   logic [ACC_W-1:0]    val_ff, val_in, vcur_ff, vcur_in;
   logic [RW-1:0]       rr_ff, rr_in, wr_ff, wr_in;
   logic [CW-1:0]       cc_ff, cc_in, cc0_ff, cc0_in, wc_ff, wc_in;
   logic [WA-1:0]       wprod_ff, wprod_in;
   logic [ACC_W-1:0]    sp_ff, sp_in, sr_ff, sr_in, sc_ff, sc_in, sb_ff, sb_in;
   logic [PW-1:0]       mp_ff, mp_in;
   logic [ACC_W-1:0]    macc_ff, macc_in;
   logic [ACC_W-1:0]    pr0_ff, pr0_in, pr1_ff, pr1_in, pr2_ff, pr2_in;
   logic [ACC_W-1:0]    total_ff, total_in;
   logic signed [RESULT_W-1:0] rsp_sum_ff, rsp_sum_in;
   logic                rsp_oor_ff, rsp_oor_in;

   logic [MW-1:0]       mem_tree [CELLS];
   logic [MW-1:0]       mem_rdata_ff;
   logic [MW-1:0]       mem_wdata;
   logic [AW-1:0]       mem_waddr;
   logic                mem_we, mem_re;

   logic                accept, bad, qry, neg;
   logic                row_done, col_done;
   logic [RW-1:0]       rr_low, base_r;
   logic [CW-1:0]       cc_low, base_c;
   logic [AW-1:0]       row_idx, cell_addr;
   logic [WA-1:0]       mul_a;
   logic [ACC_W-1:0]    mul_b, prod, term;
   logic [HALF_W-1:0]   mul_bh;
   logic [PW-1:0]       mul_p;
   logic [SUM_WIDTH-1:0] fld_plain, fld_row, fld_col, fld_both, total_sw;

   assign busy             = state_ff != ST_IDLE;
   assign accept           = start && !busy;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_rect_sum     = rsp_sum_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   assign qry = cmd_ff == CMD_QUERY;
   assign neg = k_ff[0] ^ k_ff[1];

   assign bad = (CFG_W'(req_row_lo) >= rows_in_use_ff) || (CFG_W'(req_row_hi) >= rows_in_use_ff)
             || (CFG_W'(req_col_lo) >= cols_in_use_ff) || (CFG_W'(req_col_hi) >= cols_in_use_ff)
             || (int'(req_row_lo) >= MAX_ROWS) || (int'(req_row_hi) >= MAX_ROWS)
             || (int'(req_col_lo) >= MAX_COLS) || (int'(req_col_hi) >= MAX_COLS);

   // tree walk
   assign rr_low    = rr_ff & (~rr_ff + RW'(1));
   assign cc_low    = cc_ff & (~cc_ff + CW'(1));
   assign row_done  = qry ? (rr_ff == '0) : (rr_ff > RW'(MAX_ROWS));
   assign col_done  = qry ? (cc_ff == '0) : (cc_ff > CW'(MAX_COLS));
   assign row_idx   = AW'(rr_ff - RW'(1));
   assign cell_addr = AW'(row_idx * AW'(MAX_COLS)) + AW'(cc_ff - CW'(1));

   assign base_r = k_ff[1] ? (RW'(rh_ff) + RW'(1)) : RW'(rl_ff);
   assign base_c = k_ff[0] ? (CW'(ch_ff) + CW'(1)) : CW'(cl_ff);

   assign fld_plain = mem_rdata_ff[SUM_WIDTH-1:0];
   assign fld_row   = mem_rdata_ff[2*SUM_WIDTH-1:SUM_WIDTH];
   assign fld_col   = mem_rdata_ff[3*SUM_WIDTH-1:2*SUM_WIDTH];
   assign fld_both  = mem_rdata_ff[4*SUM_WIDTH-1:3*SUM_WIDTH];

   // shared multiplier, weight times one half of a 64-bit word
   always_comb begin
      case (mop_ff)
         2'd0:    mul_a = WA'(wr_ff);
         2'd1:    mul_a = WA'(wc_ff);
         default: mul_a = wprod_ff;
      endcase
      if (!qry) begin
         mul_b = vcur_ff;
      end else begin
         case (mop_ff)
            2'd0:    mul_b = sc_ff;
            2'd1:    mul_b = sr_ff;
            default: mul_b = sp_ff;
         endcase
      end
      mul_bh = (mph_ff == 2'd0) ? mul_b[HALF_W-1:0] : mul_b[ACC_W-1:HALF_W];
      mul_p  = PW'(mul_a) * PW'(mul_bh);
      prod   = macc_ff + (ACC_W'(mp_ff) << HALF_W);
      term   = pr2_ff - pr1_ff - pr0_ff + sb_ff;
   end

   always_comb begin
      mem_waddr = (state_ff == ST_CLEAR) ? clr_ff : cell_addr;
      if (state_ff == ST_CLEAR) begin
         mem_wdata = '0;
      end else begin
         mem_wdata = {fld_both + pr2_ff[SUM_WIDTH-1:0], fld_col + pr1_ff[SUM_WIDTH-1:0],
                      fld_row + pr0_ff[SUM_WIDTH-1:0], fld_plain + vcur_ff[SUM_WIDTH-1:0]};
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      k_in         = k_ff;
      mop_in       = mop_ff;
      mph_in       = mph_ff;
      rsp_valid_in = 1'b0;
      cmd_in       = cmd_ff;
      rl_in        = rl_ff;
      cl_in        = cl_ff;
      rh_in        = rh_ff;
      ch_in        = ch_ff;
      val_in       = val_ff;
      vcur_in      = vcur_ff;
      rr_in        = rr_ff;
      cc_in        = cc_ff;
      cc0_in       = cc0_ff;
      wr_in        = wr_ff;
      wc_in        = wc_ff;
      wprod_in     = wprod_ff;
      sp_in        = sp_ff;
      sr_in        = sr_ff;
      sc_in        = sc_ff;
      sb_in        = sb_ff;
      mp_in        = mp_ff;
      macc_in      = macc_ff;
      pr0_in       = pr0_ff;
      pr1_in       = pr1_ff;
      pr2_in       = pr2_ff;
      total_in     = total_ff;
      rsp_sum_in   = rsp_sum_ff;
      rsp_oor_in   = rsp_oor_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      total_sw     = total_ff[SUM_WIDTH-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               rl_in  = req_row_lo;
               cl_in  = req_col_lo;
               rh_in  = req_row_hi;
               ch_in  = req_col_hi;
               val_in = ACC_W'(req_add_value);
               if (bad) begin
                  if (req_cmd == CMD_QUERY) begin
                     rsp_valid_in = 1'b1;
                     rsp_sum_in   = '0;
                     rsp_oor_in   = 1'b1;
                  end
               end else begin
                  k_in     = 2'd0;
                  total_in = '0;
                  state_in = ST_SETUP;
               end
            end
         end
         ST_SETUP: begin
            wr_in    = base_r + RW'(1);
            wc_in    = base_c + CW'(1);
            rr_in    = qry ? base_r : (base_r + RW'(1));
            cc_in    = qry ? base_c : (base_c + CW'(1));
            cc0_in   = qry ? base_c : (base_c + CW'(1));
            vcur_in  = neg ? ('0 - val_ff) : val_ff;
            sp_in    = '0;
            sr_in    = '0;
            sc_in    = '0;
            sb_in    = '0;
            mop_in   = 2'd0;
            mph_in   = 2'd0;
            state_in = ST_WPROD;
         end
         ST_WPROD: begin
            wprod_in = WA'(wr_ff) * WA'(wc_ff);
            state_in = qry ? ST_WALK_RD : ST_MUL;
         end
         ST_MUL: begin
            mp_in = mul_p;
            case (mph_ff)
               2'd0: begin
                  mph_in = 2'd1;
               end
               2'd1: begin
                  macc_in = ACC_W'(mp_ff);
                  mph_in  = 2'd2;
               end
               default: begin
                  mph_in = 2'd0;
                  case (mop_ff)
                     2'd0:    pr0_in = prod;
                     2'd1:    pr1_in = prod;
                     default: pr2_in = prod;
                  endcase
                  if (mop_ff == 2'd2) begin
                     mop_in   = 2'd0;
                     state_in = qry ? ST_COMBINE : ST_WALK_RD;
                  end else begin
                     mop_in = mop_ff + 2'd1;
                  end
               end
            endcase
         end
         ST_WALK_RD: begin
            if (row_done) begin
               if (qry) begin
                  state_in = ST_MUL;
               end else if (k_ff == 2'd3) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_SETUP;
               end
            end else if (col_done) begin
               rr_in = qry ? (rr_ff - rr_low) : (rr_ff + rr_low);
               cc_in = cc0_ff;
            end else begin
               mem_re   = 1'b1;
               state_in = ST_WALK_WR;
            end
         end
         ST_WALK_WR: begin
            if (qry) begin
               sp_in = sp_ff + ACC_W'(fld_plain);
               sr_in = sr_ff + ACC_W'(fld_row);
               sc_in = sc_ff + ACC_W'(fld_col);
               sb_in = sb_ff + ACC_W'(fld_both);
            end else begin
               mem_we = 1'b1;
            end
            cc_in    = qry ? (cc_ff - cc_low) : (cc_ff + cc_low);
            state_in = ST_WALK_RD;
         end
         ST_COMBINE: begin
            total_in = neg ? (total_ff - term) : (total_ff + term);
            total_sw = total_in[SUM_WIDTH-1:0];
            if (k_ff == 2'd3) begin
               rsp_valid_in = 1'b1;
               rsp_sum_in   = RESULT_W'($signed(total_sw));
               rsp_oor_in   = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               k_in     = k_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         k_ff         <= 2'd0;
         mop_ff       <= 2'd0;
         mph_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         k_ff         <= k_in;
         mop_ff       <= mop_in;
         mph_ff       <= mph_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      rl_ff      <= rl_in;
      cl_ff      <= cl_in;
      rh_ff      <= rh_in;
      ch_ff      <= ch_in;
      val_ff     <= val_in;
      vcur_ff    <= vcur_in;
      rr_ff      <= rr_in;
      cc_ff      <= cc_in;
      cc0_ff     <= cc0_in;
      wr_ff      <= wr_in;
      wc_ff      <= wc_in;
      wprod_ff   <= wprod_in;
      sp_ff      <= sp_in;
      sr_ff      <= sr_in;
      sc_ff      <= sc_in;
      sb_ff      <= sb_in;
      mp_ff      <= mp_in;
      macc_ff    <= macc_in;
      pr0_ff     <= pr0_in;
      pr1_ff     <= pr1_in;
      pr2_ff     <= pr2_in;
      total_ff   <= total_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_oor_ff <= rsp_oor_in;
   end

   // tree memory, one word per cell holding all four trees
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_tree[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_rdata_ff <= mem_tree[cell_addr];
      end
   end

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= SIZE_RESET;
         cols_in_use_ff <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata;
            CSR_COLS_IN_USE: cols_in_use_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

endmodule

[rtl/core/rars2d_checker.sv]
`include "range_add_range_sum_2d_fenwick_defines.svh"

module rars2d_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    start,
   input logic                                    busy,
   input logic                                    req_cmd,
   input logic                                    rsp_valid,
   input logic signed [rars2d_pkg::RESULT_W-1:0]  rsp_rect_sum,
   input logic                                    rsp_out_of_range
);

   import rars2d_pkg::*;

   // out of range answers carry no sum
   `RARS2D_ASSERT_SAME(a_oor_zero, clock, reset, rsp_valid && rsp_out_of_range, rsp_rect_sum == '0, "out of range response with nonzero sum")
   // a response only comes once the command is finished
   `RARS2D_ASSERT_SAME(a_rsp_not_busy, clock, reset, rsp_valid, !busy, "response while busy")
   // reset starts the memory clearing pass
   `RARS2D_ASSERT_NEXT(a_reset_clear, clock, reset, busy, "not busy after reset")
   // an add transfer never causes a response
   `RARS2D_ASSERT_NEXT(a_add_silent, clock, start && !busy && req_cmd == CMD_ADD, !rsp_valid, "response after add")

endmodule

bind range_add_range_sum_2d_fenwick rars2d_checker u_rars2d_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_rect_sum     (rsp_rect_sum),
   .rsp_out_of_range (rsp_out_of_range)
);
